FILE: src/bosd_pkg.sv
package bosd_pkg;

    localparam int SEGMENT_ENTRIES    = 16;
    localparam int POINTER_BYTES      = 4;
    localparam int REGION_OFFSET_BITS = 24;

    localparam int SEG_IDX_W = (SEGMENT_ENTRIES > 1) ? $clog2(SEGMENT_ENTRIES) : 1;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 160;
    localparam int SYM_OUT_W  = 24;

    localparam logic [31:0] PTR_BYTES = 32'(POINTER_BYTES);

    localparam logic [3:0] OP_DONE          = 4'h0;
    localparam logic [3:0] OP_ORD_IMM       = 4'h1;
    localparam logic [3:0] OP_ORD_ULEB      = 4'h2;
    localparam logic [3:0] OP_ORD_SPECIAL   = 4'h3;
    localparam logic [3:0] OP_SET_SYMBOL    = 4'h4;
    localparam logic [3:0] OP_SET_TYPE      = 4'h5;
    localparam logic [3:0] OP_SET_ADDEND    = 4'h6;
    localparam logic [3:0] OP_SET_SEG_OFF   = 4'h7;
    localparam logic [3:0] OP_ADD_ADDR      = 4'h8;
    localparam logic [3:0] OP_BIND          = 4'h9;
    localparam logic [3:0] OP_BIND_ADD_ULEB = 4'hA;
    localparam logic [3:0] OP_BIND_ADD_IMM  = 4'hB;
    localparam logic [3:0] OP_BIND_REPEAT   = 4'hC;

    localparam logic CMD_STREAM  = 1'b0;
    localparam logic CMD_SEGMENT = 1'b1;

    typedef enum logic [8:0] {
        PH_OPCODE        = 9'b000000001,
        PH_ORD_ULEB      = 9'b000000010,
        PH_STRING        = 9'b000000100,
        PH_SLEB          = 9'b000001000,
        PH_SEG_ULEB      = 9'b000010000,
        PH_ADD_ULEB      = 9'b000100000,
        PH_BIND_ADD_ULEB = 9'b001000000,
        PH_COUNT_ULEB    = 9'b010000000,
        PH_SKIP_ULEB     = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic                          symbol_valid;
        logic [SYM_OUT_W-1:0]          symbol_offset;
        logic [31:0]                   library_ordinal;
        logic [31:0]                   slot_stride;
        logic [31:0]                   repeat_count;
        logic [31:0]                   bind_address;
    } t_record;

endpackage

FILE: src/bind_opcode_stream_decoder_top.sv
// Channel   Dir  Beat fields (tdata low bit up)                              Accept
// s         in   tdata: data_byte[7:0] region_start[8] segment_index[12:9]   tvalid & tready
//                       segment_base[44:13]; tuser: cmd
// m         out  tdata: bind_address[31:0] repeat_count[63:32]              tvalid & tready
//                       slot_stride[95:64] library_ordinal[127:96]
//                       symbol_offset[151:128] symbol_valid[152]
//
// One beat per cycle sustained while the output is taken: a beat is captured in the input
// register, decoded against the parse state, and any run record lands in the output register.
// A run record is registered: its beat passes the input register, then the output register.
// Synchronous active-low reset clears the parse state (all but the run end), segment table and both valids.
// A full output register that is not taken holds the decode stage, and the input
// register then holds its beat; beats that produce no record also wait.
module bind_opcode_stream_decoder_top
    import bosd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // data_byte, region_start, segment_index, segment_base, zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // cmd
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // bind_address, repeat_count, slot_stride, library_ordinal,
    // symbol_offset, symbol_valid, zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    logic                          r_in_valid;
    logic                          r_cmd;
    logic [7:0]                    r_byte;
    logic                          r_rs;
    logic [3:0]                    r_seg_idx;
    logic [31:0]                   r_seg_val;

    logic [31:0]                   r_seg_base [SEGMENT_ENTRIES];
    t_phase                        r_phase,   n_phase;
    logic [31:0]                   r_acc,     n_acc;
    logic [5:0]                    r_shift,   n_shift;
    logic [31:0]                   r_ord,     n_ord;
    logic [REGION_OFFSET_BITS-1:0] r_sym,     n_sym;
    logic                          r_symv,    n_symv;
    logic [31:0]                   r_addr,    n_addr;
    logic [31:0]                   r_cnt,     n_cnt;
    logic [3:0]                    r_pseg,    n_pseg;
    logic [REGION_OFFSET_BITS-1:0] r_pos,     n_pos;
    logic [31:0]                   r_run_end, n_run_end;

    logic                          r_out_valid;
    t_record                       r_out,     n_out;
    logic                          n_emit;

    t_phase                        e_phase;
    logic [31:0]                   e_acc, e_ord, e_addr, e_cnt;
    logic [5:0]                    e_shift;
    logic [REGION_OFFSET_BITS-1:0] e_sym, e_pos;
    logic                          e_symv;
    logic [3:0]                    e_pseg;

    logic [3:0]                    op, imm;
    logic [31:0]                   b7;
    logic                          take_en;
    logic [31:0]                   acc_new;
    logic [5:0]                    shift_new;
    logic                          uleb_done;
    logic [31:0]                   skip_prod, skip_term;
    logic [31:0]                   seg_rd, stride;
    logic                          advance;
    logic                          seg_wr;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_cmd     <= i_s_tuser;
            r_byte    <= i_s_tdata[7:0];
            r_rs      <= i_s_tdata[8];
            r_seg_idx <= i_s_tdata[12:9];
            r_seg_val <= i_s_tdata[44:13];
        end
    end

    always_comb begin
        e_phase = r_rs ? PH_OPCODE : r_phase;
        e_acc   = r_rs ? '0 : r_acc;
        e_shift = r_rs ? '0 : r_shift;
        e_ord   = r_rs ? '0 : r_ord;
        e_sym   = r_rs ? '0 : r_sym;
        e_symv  = r_rs ? 1'b0 : r_symv;
        e_addr  = r_rs ? '0 : r_addr;
        e_cnt   = r_rs ? '0 : r_cnt;
        e_pseg  = r_rs ? '0 : r_pseg;
        e_pos   = r_rs ? '0 : r_pos;
    end

    assign op        = r_byte[7:4];
    assign imm       = r_byte[3:0];
    assign b7        = {25'd0, r_byte[6:0]};
    assign take_en   = e_shift < 6'd32;
    assign acc_new   = e_acc | (take_en ? 32'(64'(b7) << e_shift) : 32'd0);
    assign shift_new = take_en ? e_shift + 6'd7 : e_shift;
    assign uleb_done = !r_byte[7];
    assign skip_prod = 32'(e_cnt * b7);
    assign skip_term = take_en ? 32'(skip_prod << e_shift) : 32'd0;
    assign seg_wr    = (r_cmd == CMD_SEGMENT) && (5'(r_seg_idx) < 5'(SEGMENT_ENTRIES));
    assign seg_rd    = (5'(e_pseg) < 5'(SEGMENT_ENTRIES))
                     ? r_seg_base[SEG_IDX_W'(e_pseg)] : 32'd0;

    always_comb begin
        n_phase   = e_phase;
        n_acc     = e_acc;
        n_shift   = e_shift;
        n_ord     = e_ord;
        n_sym     = e_sym;
        n_symv    = e_symv;
        n_addr    = e_addr;
        n_cnt     = e_cnt;
        n_pseg    = e_pseg;
        n_pos     = e_pos;
        n_run_end = r_run_end;
        n_emit    = 1'b0;
        stride    = PTR_BYTES;
        n_out.bind_address    = e_addr;
        n_out.repeat_count    = 32'd1;
        n_out.slot_stride     = PTR_BYTES;
        n_out.library_ordinal = e_ord;
        n_out.symbol_offset   = e_symv ? SYM_OUT_W'(e_sym) : '0;
        n_out.symbol_valid    = e_symv;

        if (r_cmd == CMD_STREAM) begin
            n_pos = e_pos + 1'b1;
            case (e_phase)
                PH_OPCODE: begin
                    case (op)
                        OP_ORD_IMM: begin
                            n_ord = {28'd0, imm};
                        end
                        OP_ORD_ULEB: begin
                            n_acc   = '0;
                            n_shift = '0;
                            n_phase = PH_ORD_ULEB;
                        end
                        OP_ORD_SPECIAL: begin
                            n_ord = (imm == 4'd0) ? 32'd0 : {28'hFFFFFFF, imm};
                        end
                        OP_SET_SYMBOL: begin
                            n_sym   = e_pos + 1'b1;
                            n_symv  = 1'b1;
                            n_phase = PH_STRING;
                        end
                        OP_SET_ADDEND: begin
                            n_phase = PH_SLEB;
                        end
                        OP_SET_SEG_OFF: begin
                            n_pseg  = imm;
                            n_acc   = '0;
                            n_shift = '0;
                            n_phase = PH_SEG_ULEB;
                        end
                        OP_ADD_ADDR: begin
                            n_acc   = '0;
                            n_shift = '0;
                            n_phase = PH_ADD_ULEB;
                        end
                        OP_BIND: begin
                            n_emit = 1'b1;
                            n_addr = e_addr + PTR_BYTES;
                        end
                        OP_BIND_ADD_ULEB: begin
                            n_acc   = '0;
                            n_shift = '0;
                            n_phase = PH_BIND_ADD_ULEB;
                        end
                        OP_BIND_ADD_IMM: begin
                            stride            = 32'((32'(imm) + 32'd1) * PTR_BYTES);
                            n_emit            = 1'b1;
                            n_out.slot_stride = stride;
                            n_addr            = e_addr + stride;
                        end
                        OP_BIND_REPEAT: begin
                            n_acc   = '0;
                            n_shift = '0;
                            n_phase = PH_COUNT_ULEB;
                        end
                        default: begin
                        end
                    endcase
                end
                PH_STRING: begin
                    if (r_byte == 8'd0) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_SLEB: begin
                    if (uleb_done) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_ORD_ULEB, PH_SEG_ULEB, PH_ADD_ULEB, PH_BIND_ADD_ULEB: begin
                    n_acc   = acc_new;
                    n_shift = shift_new;
                    if (uleb_done) begin
                        n_phase = PH_OPCODE;
                        case (e_phase)
                            PH_ORD_ULEB: begin
                                n_ord = acc_new;
                            end
                            PH_SEG_ULEB: begin
                                n_addr = seg_rd + acc_new;
                            end
                            PH_ADD_ULEB: begin
                                n_addr = e_addr + acc_new;
                            end
                            default: begin
                                stride            = PTR_BYTES + acc_new;
                                n_emit            = 1'b1;
                                n_out.slot_stride = stride;
                                n_addr            = e_addr + stride;
                            end
                        endcase
                    end
                end
                PH_COUNT_ULEB: begin
                    n_acc   = acc_new;
                    n_shift = shift_new;
                    if (uleb_done) begin
                        n_cnt     = acc_new;
                        n_run_end = e_addr + 32'(acc_new * PTR_BYTES);
                        n_acc     = '0;
                        n_shift   = '0;
                        n_phase   = PH_SKIP_ULEB;
                    end
                end
                PH_SKIP_ULEB: begin
                    n_acc     = acc_new;
                    n_shift   = shift_new;
                    n_run_end = r_run_end + skip_term;
                    if (uleb_done) begin
                        n_emit             = 1'b1;
                        n_out.repeat_count = e_cnt;
                        n_out.slot_stride  = acc_new + PTR_BYTES;
                        n_addr             = r_run_end + skip_term;
                        n_phase            = PH_OPCODE;
                    end
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_acc   <= '0;
            r_shift <= '0;
            r_ord   <= '0;
            r_sym   <= '0;
            r_symv  <= 1'b0;
            r_addr  <= '0;
            r_cnt   <= '0;
            r_pseg  <= '0;
            r_pos   <= '0;
            for (int i = 0; i < SEGMENT_ENTRIES; i++) begin
                r_seg_base[i] <= '0;
            end
        end else if (advance) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_shift <= n_shift;
            r_ord   <= n_ord;
            r_sym   <= n_sym;
            r_symv  <= n_symv;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_pseg  <= n_pseg;
            r_pos   <= n_pos;
            if (seg_wr) begin
                r_seg_base[SEG_IDX_W'(r_seg_idx)] <= r_seg_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_run_end <= n_run_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

endmodule
